// ----- design/sbus_frame_channel_decoder_assert.svh -----
// ----------------------------------------------------------------------------
// SBUS frame channel decoder assertion macros
// Shared assertion wrappers for the decoder's checker.
// ----------------------------------------------------------------------------
`ifndef SBUS_FRAME_CHANNEL_DECODER_ASSERT_SVH
`define SBUS_FRAME_CHANNEL_DECODER_ASSERT_SVH

// Property checked on every rising clock edge while reset is released.
`define SFCD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Property checked on every rising clock edge, reset included.
`define SFCD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ----- design/sfcd_pkg.sv -----
// ----------------------------------------------------------------------------
// SBUS frame channel decoder package
// Frame constants, register indexes and the switch quantizer.
// ----------------------------------------------------------------------------
package sfcd_pkg;

    localparam int unsigned STORE_DEPTH = 22;
    localparam int unsigned CH_W        = 11;
    localparam int unsigned CTR_W       = CH_W + 1;
    localparam int unsigned AXIS_W      = 18;
    localparam int unsigned SW_W        = 3;
    localparam int unsigned GAIN_W      = 6;
    localparam int unsigned POS_W       = 5;
    localparam int unsigned NUM_AXIS    = 5;
    localparam int unsigned NUM_SW      = 4;

    localparam logic [7:0] HDR_BYTE = 8'h0F;
    localparam logic [7:0] END_BYTE = 8'h00;

    localparam logic [POS_W-1:0] POS_HDR     = 5'd0;
    localparam logic [POS_W-1:0] POS_LAST_PL = 5'd22;
    localparam logic [POS_W-1:0] POS_END     = 5'd24;
    localparam logic [POS_W-1:0] POS_WAIT    = 5'd25;

    localparam logic [CH_W-1:0]   CENTER_RST = 11'd992;
    localparam logic [GAIN_W-1:0] GAIN_RST   = 6'd10;

    localparam logic [CTR_W-1:0] SWITCH_DIV  = 12'd800;
    localparam logic [CTR_W-1:0] SWITCH_DIV2 = 12'd1600;

    // Configuration register indexes.
    typedef enum logic {
        CFG_STICK_CENTER = 1'b0,
        CFG_AXIS_GAIN    = 1'b1
    } cfg_index_t;

    // Raw channel numbers of the axis and switch outputs, in output order.
    localparam int unsigned AXIS_CH [NUM_AXIS] = '{3, 2, 0, 8, 9};
    localparam int unsigned SW_CH   [NUM_SW]   = '{4, 5, 6, 7};

    // Centered channel divided by 800, truncated toward zero. The centered
    // value lies within +-2047, so the quotient is one of -2..2.
    function automatic logic signed [SW_W-1:0] switch_value(
        input logic signed [CTR_W-1:0] v
    );
        logic [CTR_W-1:0] mag;
        logic [SW_W-1:0]  q;
        mag = v[CTR_W-1] ? (~v + 1'b1) : v;
        if (mag >= SWITCH_DIV2) begin
            q = 3'd2;
        end else if (mag >= SWITCH_DIV) begin
            q = 3'd1;
        end else begin
            q = 3'd0;
        end
        return v[CTR_W-1] ? $signed(~q + 1'b1) : $signed(q);
    endfunction

endpackage

// ----- design/sfcd_cell.sv -----
// ----------------------------------------------------------------------------
// SBUS frame channel decoder byte cell
// One stage of the payload shift line; takes its neighbor's byte on a shift.
// ----------------------------------------------------------------------------
module sfcd_cell (
    input  logic       aclk,
    input  logic       shift_en,
    input  logic [7:0] d_in,
    output logic [7:0] q
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb begin
        byte_next = shift_en ? d_in : byte_reg;
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign q = byte_reg;

endmodule

// ----- design/sbus_frame_channel_decoder.sv -----
// ----------------------------------------------------------------------------
// SBUS frame channel decoder
// Decodes 25-byte frames into scaled axis values and switch positions.
// ----------------------------------------------------------------------------
// Throughput: one byte transfer per clock cycle while s_tready is high; it
// drops when stage one and a stalled output register both hold a result.
// The end byte's transfer loads stage one; it moves on once the output frees.
// Reset (aresetn low, synchronous) returns the decoder to waiting for a
// chunk start, clears the header flag and both pipeline valids, and restores
// stick_center to 992 and axis_gain to 10. The payload cells are not reset.
// ----------------------------------------------------------------------------
module sbus_frame_channel_decoder (
    input  logic         aclk,
    input  logic         aresetn,
    // Received bytes.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    input  logic [0:0]   s_tuser,   // [0] chunk_start
    // Decoded frames.
    output logic         m_tvalid,
    input  logic         m_tready,
    // [17:0] axis_vy, [35:18] axis_vx, [53:36] axis_turn,
    // [56:54] button_one, [59:57] button_two, [62:60] button_three,
    // [65:63] button_four, [83:66] lever_five, [101:84] lever_six,
    // [103:102] zero
    output logic [103:0] m_tdata,
    // Configuration writes.
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [10:0]  cfg_data
);

    import sfcd_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken.
    // ------------------------------------------------------------------
    logic [CH_W-1:0]   center_reg, center_next;
    logic [GAIN_W-1:0] gain_reg, gain_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        center_next = center_reg;
        gain_next   = gain_reg;
        if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_STICK_CENTER: center_next = cfg_data;
                CFG_AXIS_GAIN:    gain_next   = cfg_data[GAIN_W-1:0];
                default:          center_next = center_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg <= CENTER_RST;
            gain_reg   <= GAIN_RST;
        end else begin
            center_reg <= center_next;
            gain_reg   <= gain_next;
        end
    end

    // ------------------------------------------------------------------
    // Frame position tracking. A chunk start always restarts at byte 0;
    // without one, a decoder in the wait position ignores the byte.
    // ------------------------------------------------------------------
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             hdr_good_reg, hdr_good_next;
    logic [POS_W-1:0] pos_cur;
    logic             s_xfer;
    logic             shift_en;
    logic             frame_ok;

    logic stage_valid_reg, stage_valid_next;
    logic out_valid_reg, out_valid_next;
    logic advance;

    assign s_xfer  = s_tvalid && s_tready;
    assign pos_cur = s_tuser[0] ? POS_HDR : pos_reg;

    always_comb begin
        pos_next      = pos_reg;
        hdr_good_next = hdr_good_reg;
        shift_en      = 1'b0;
        frame_ok      = 1'b0;
        if (s_xfer && (pos_cur < POS_WAIT)) begin
            if (pos_cur == POS_HDR) begin
                hdr_good_next = (s_tdata == HDR_BYTE);
                pos_next      = pos_cur + 5'd1;
            end else if (pos_cur == POS_END) begin
                // Frame complete either way; wait for the next chunk start.
                pos_next = POS_WAIT;
                frame_ok = hdr_good_reg && (s_tdata == END_BYTE);
            end else begin
                // Bytes 1..22 enter the shift line; byte 23 is skipped.
                shift_en = (pos_cur <= POS_LAST_PL);
                pos_next = pos_cur + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= POS_WAIT;
            hdr_good_reg <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            hdr_good_reg <= hdr_good_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload shift line. Each byte enters the top cell and moves down one
    // cell per payload byte, so after byte 22 cell k holds frame byte k+1.
    // ------------------------------------------------------------------
    logic [7:0] cell_q [STORE_DEPTH];
    logic [STORE_DEPTH*8-1:0] payload;

    genvar gi;
    generate
        for (gi = 0; gi < STORE_DEPTH; gi++) begin : g_cell
            if (gi == STORE_DEPTH - 1) begin : g_top
                sfcd_cell u_cell (
                    .aclk     (aclk),
                    .shift_en (shift_en),
                    .d_in     (s_tdata),
                    .q        (cell_q[gi])
                );
            end else begin : g_mid
                sfcd_cell u_cell (
                    .aclk     (aclk),
                    .shift_en (shift_en),
                    .d_in     (cell_q[gi+1]),
                    .q        (cell_q[gi])
                );
            end
            assign payload[gi*8 +: 8] = cell_q[gi];
        end
    endgenerate

    // ------------------------------------------------------------------
    // Stage one: centered channels, captured when a good frame ends.
    // Channel c sits at payload bits 11*c and up.
    // ------------------------------------------------------------------
    logic signed [CTR_W-1:0] axis_ctr_reg [NUM_AXIS];
    logic signed [CTR_W-1:0] sw_ctr_reg   [NUM_SW];

    generate
        for (gi = 0; gi < NUM_AXIS; gi++) begin : g_axis_ctr
            always_ff @(posedge aclk) begin
                if (frame_ok) begin
                    axis_ctr_reg[gi] <= $signed({1'b0, payload[AXIS_CH[gi]*CH_W +: CH_W]})
                                      - $signed({1'b0, center_reg});
                end
            end
        end
        for (gi = 0; gi < NUM_SW; gi++) begin : g_sw_ctr
            always_ff @(posedge aclk) begin
                if (frame_ok) begin
                    sw_ctr_reg[gi] <= $signed({1'b0, payload[SW_CH[gi]*CH_W +: CH_W]})
                                    - $signed({1'b0, center_reg});
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Stage two: scaling and quantizing into the output register. The
    // stage moves on whenever the output register is empty or being
    // drained; bytes flow while a result waits if stage one is empty.
    // ------------------------------------------------------------------
    logic signed [AXIS_W-1:0] axis_out_reg [NUM_AXIS];
    logic signed [SW_W-1:0]   sw_out_reg   [NUM_SW];

    assign advance  = stage_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !stage_valid_reg || !out_valid_reg || m_tready;

    generate
        for (gi = 0; gi < NUM_AXIS; gi++) begin : g_axis_mul
            logic signed [CTR_W+GAIN_W:0] prod;
            assign prod = axis_ctr_reg[gi] * $signed({1'b0, gain_reg});
            always_ff @(posedge aclk) begin
                if (advance) begin
                    axis_out_reg[gi] <= prod[AXIS_W-1:0];
                end
            end
        end
        for (gi = 0; gi < NUM_SW; gi++) begin : g_sw_q
            always_ff @(posedge aclk) begin
                if (advance) begin
                    sw_out_reg[gi] <= switch_value(sw_ctr_reg[gi]);
                end
            end
        end
    endgenerate

    always_comb begin
        stage_valid_next = stage_valid_reg;
        if (frame_ok) begin
            stage_valid_next = 1'b1;
        end else if (advance) begin
            stage_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    assign m_tvalid          = out_valid_reg;
    assign m_tdata[17:0]     = axis_out_reg[0];
    assign m_tdata[35:18]    = axis_out_reg[1];
    assign m_tdata[53:36]    = axis_out_reg[2];
    assign m_tdata[56:54]    = sw_out_reg[0];
    assign m_tdata[59:57]    = sw_out_reg[1];
    assign m_tdata[62:60]    = sw_out_reg[2];
    assign m_tdata[65:63]    = sw_out_reg[3];
    assign m_tdata[83:66]    = axis_out_reg[3];
    assign m_tdata[101:84]   = axis_out_reg[4];
    assign m_tdata[103:102]  = 2'b00;

endmodule

// ----- design/sfcd_checker.sv -----
// ----------------------------------------------------------------------------
// SBUS frame channel decoder checker
// Port-level checks on the decoder's result and configuration channels.
// ----------------------------------------------------------------------------
`include "sbus_frame_channel_decoder_assert.svh"

module sfcd_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata,
    input logic         cfg_ready
);

    // A stalled result stays offered.
    `SFCD_ASSERT(a_hold_valid, aclk, aresetn, (m_tvalid && !m_tready) |=> m_tvalid, "result dropped while stalled")

    // A stalled result keeps its data.
    `SFCD_ASSERT(a_hold_data, aclk, aresetn, (m_tvalid && !m_tready) |=> $stable(m_tdata), "result data changed while stalled")

    // button_one and button_four are quantized to -2..2, never 3 or -4.
    `SFCD_ASSERT(a_switch_range, aclk, aresetn, m_tvalid |-> (m_tdata[56:54] != 3'b011 && m_tdata[56:54] != 3'b100 && m_tdata[65:63] != 3'b011 && m_tdata[65:63] != 3'b100), "switch value out of range")

    // Reset empties the result register.
    `SFCD_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result offered after reset")

    // Configuration writes are never refused.
    `SFCD_ASSERT(a_cfg_ready, aclk, aresetn, cfg_ready, "configuration channel not ready")

endmodule

bind sbus_frame_channel_decoder sfcd_checker u_sfcd_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_ready (cfg_ready)
);

// ----- dv/sbus_frame_channel_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// SBUS frame channel decoder testbench
// Sends received-link bytes, predicts each decoded frame and checks every
// result transfer field by field against the prediction.
// ----------------------------------------------------------------------------
module sbus_frame_channel_decoder_tb;

    import sfcd_pkg::*;

    localparam int QUIET_LIMIT  = 3000;  // cycles without any transfer
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 6;     // covers the two-stage result pipeline
    localparam int FRAME_LEN    = 25;

    // Result layout of m_tdata, highest field first.
    typedef struct packed {
        logic [1:0]         pad;
        logic signed [17:0] lever_six;
        logic signed [17:0] lever_five;
        logic signed [2:0]  button_four;
        logic signed [2:0]  button_three;
        logic signed [2:0]  button_two;
        logic signed [2:0]  button_one;
        logic signed [17:0] axis_turn;
        logic signed [17:0] axis_vx;
        logic signed [17:0] axis_vy;
    } chan_frame_t;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata   = '0;   // [7:0] rx_byte
    logic [0:0]   s_tuser   = '0;   // [0] chunk_start
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [103:0] m_tdata;          // see chan_frame_t
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [0:0]   cfg_index = CFG_STICK_CENTER;
    logic [10:0]  cfg_data  = '0;

    sbus_frame_channel_decoder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Decoder prediction state.
    int          dec_pos    = POS_WAIT;
    bit          dec_hdr_ok = 1'b0;
    logic [7:0]  dec_store [STORE_DEPTH];
    logic [10:0] cur_center = CENTER_RST;
    logic [5:0]  cur_gain   = GAIN_RST;

    chan_frame_t frames_due [$];

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int hold_ask      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    int mismatches      = 0;
    int bytes_sent      = 0;
    int frames_sent     = 0;
    int results_checked = 0;
    int settings_used   = 1;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic int raw_channel(input int c);
        logic [8*STORE_DEPTH-1:0] flat;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            flat[8*i +: 8] = dec_store[i];
        end
        return int'(flat[11*c +: 11]);
    endfunction

    function automatic logic signed [17:0] axis_value(input int c);
        int v;
        v = (raw_channel(c) - int'(cur_center)) * int'(cur_gain);
        return v[17:0];
    endfunction

    function automatic logic signed [2:0] switch_pos(input int c);
        int v;
        v = (raw_channel(c) - int'(cur_center)) / int'(SWITCH_DIV);
        return v[2:0];
    endfunction

    // Advances the frame tracker by one byte; returns 1 when a frame decodes.
    function automatic bit decode_byte(input logic [7:0] b, input logic first,
                                       output chan_frame_t res);
        res = '0;
        if (first) begin
            dec_pos = POS_HDR;
        end
        if (dec_pos >= POS_WAIT) begin
            return 1'b0;
        end
        if (dec_pos == POS_HDR) begin
            dec_hdr_ok = (b == HDR_BYTE);
        end else if (dec_pos <= POS_LAST_PL) begin
            dec_store[dec_pos-1] = b;
        end else if (dec_pos == POS_END) begin
            dec_pos = POS_WAIT;
            if (!dec_hdr_ok || b != END_BYTE) begin
                return 1'b0;
            end
            res.axis_vy      = axis_value(3);
            res.axis_vx      = axis_value(2);
            res.axis_turn    = axis_value(0);
            res.button_one   = switch_pos(4);
            res.button_two   = switch_pos(5);
            res.button_three = switch_pos(6);
            res.button_four  = switch_pos(7);
            res.lever_five   = axis_value(8);
            res.lever_six    = axis_value(9);
            return 1'b1;
        end
        dec_pos = dec_pos + 1;
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: checks each transfer and paces m_tready.
    // ------------------------------------------------------------------------
    task automatic report_field(input string name, input int want, input int got);
        $display("%0t  %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
    endtask

    task automatic check_frame(input chan_frame_t got);
        chan_frame_t want;
        if (frames_due.size() == 0) begin
            $display("%0t  unexpected result: expected none, actual %h", $time, got);
            mismatches++;
            return;
        end
        want = frames_due.pop_front();
        results_checked++;
        if (got.axis_vy !== want.axis_vy)
            report_field("axis_vy", want.axis_vy, got.axis_vy);
        if (got.axis_vx !== want.axis_vx)
            report_field("axis_vx", want.axis_vx, got.axis_vx);
        if (got.axis_turn !== want.axis_turn)
            report_field("axis_turn", want.axis_turn, got.axis_turn);
        if (got.button_one !== want.button_one)
            report_field("button_one", want.button_one, got.button_one);
        if (got.button_two !== want.button_two)
            report_field("button_two", want.button_two, got.button_two);
        if (got.button_three !== want.button_three)
            report_field("button_three", want.button_three, got.button_three);
        if (got.button_four !== want.button_four)
            report_field("button_four", want.button_four, got.button_four);
        if (got.lever_five !== want.lever_five)
            report_field("lever_five", want.lever_five, got.lever_five);
        if (got.lever_six !== want.lever_six)
            report_field("lever_six", want.lever_six, got.lever_six);
        if (got.pad !== want.pad)
            report_field("padding", want.pad, got.pad);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            check_frame(chan_frame_t'(m_tdata));
        end
        // A new hold-off request starts a long stretch with m_tready low.
        if (hold_seen != hold_ask) begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Watchdog: any transfer on any channel restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t  no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // s_tvalid is left high after a transfer so that back-to-back bytes never
    // lower and raise it within one time step.
    task automatic send_byte(input logic [7:0] b, input logic first);
        chan_frame_t res;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        if (decode_byte(b, first, res)) begin
            frames_due.push_back(res);
        end
    endtask

    // Sends the first len bytes of a frame built from its parts.
    task automatic send_frame(input logic [175:0] pl, input logic [7:0] hdr,
                              input logic [7:0] tail, input logic [7:0] endb,
                              input int len);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            if (i == 0)
                b = hdr;
            else if (i <= POS_LAST_PL)
                b = pl[8*(i-1) +: 8];
            else if (i == POS_END)
                b = endb;
            else
                b = tail;
            send_byte(b, i == 0);
        end
        if (len == FRAME_LEN && hdr == HDR_BYTE && endb == END_BYTE) begin
            frames_sent++;
        end
    endtask

    task automatic send_good(input logic [175:0] pl);
        send_frame(pl, HDR_BYTE, 8'($urandom_range(255)), END_BYTE, FRAME_LEN);
    endtask

    task automatic send_noise(input int n, input int start_pct);
        for (int i = 0; i < n; i++) begin
            send_byte(8'($urandom_range(255)), $urandom_range(99) < start_pct);
        end
    endtask

    function automatic logic [175:0] same_channels(input logic [10:0] v);
        logic [175:0] pl;
        for (int c = 0; c < 16; c++) begin
            pl[11*c +: 11] = v;
        end
        return pl;
    endfunction

    // Channel values lean toward the rails and the switch thresholds around
    // the current center, so both quantizer edges are hit often.
    function automatic logic [175:0] random_payload();
        logic [175:0] pl;
        int           v;
        int           mag;
        for (int c = 0; c < 16; c++) begin
            case ($urandom_range(9))
                0: v = 0;
                1: v = 2047;
                2, 3: begin
                    case ($urandom_range(4))
                        0: mag = 799;
                        1: mag = 800;
                        2: mag = 1599;
                        3: mag = 1600;
                        default: mag = 0;
                    endcase
                    v = $urandom_range(1) ? int'(cur_center) + mag
                                          : int'(cur_center) - mag;
                    if (v < 0 || v > 2047) v = $urandom_range(2047);
                end
                default: v = $urandom_range(2047);
            endcase
            pl[11*c +: 11] = v[10:0];
        end
        return pl;
    endfunction

    // Stops sending and waits until every predicted frame has been taken.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (frames_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [10:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_STICK_CENTER)
            cur_center = val;
        else
            cur_gain = val[5:0];
    endtask

    task automatic set_config(input logic [10:0] center, input logic [5:0] gain);
        wait_drained();
        write_reg(CFG_STICK_CENTER, center);
        write_reg(CFG_AXIS_GAIN, {5'd0, gain});
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_reset_values();
        logic [175:0] pl;
        src_idle_pct  = 31;
        sink_idle_pct = 64;
        send_good(same_channels(11'd0));
        send_good(same_channels(11'd2047));
        send_good(same_channels(CENTER_RST));
        for (int c = 0; c < 16; c++) begin
            pl[11*c +: 11] = 11'(100 + 120 * c);
        end
        send_good(pl);
    endtask

    task automatic test_special_cases();
        logic [175:0] pl;
        pl = random_payload();
        // Bytes without a chunk start while waiting are dropped.
        send_byte(HDR_BYTE, 1'b0);
        send_byte(END_BYTE, 1'b0);
        send_byte(8'hA5, 1'b0);
        // A chunk start in the middle of a frame begins a new frame.
        send_frame(pl, HDR_BYTE, 8'h00, END_BYTE, 11);
        send_frame(pl, HDR_BYTE, 8'hFF, END_BYTE, FRAME_LEN);
        // Bad header, then bad end byte: neither decodes.
        send_frame(pl, 8'h0E, 8'h00, END_BYTE, FRAME_LEN);
        send_frame(pl, HDR_BYTE, 8'h00, 8'h01, FRAME_LEN);
        // Trailing bytes after the end byte are ignored until the next start.
        send_good(random_payload());
        send_byte(HDR_BYTE, 1'b0);
        send_byte(END_BYTE, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_good(random_payload());
    endtask

    task automatic test_config_extremes();
        logic [175:0] pl;
        set_config(11'd0, 6'd63);
        send_good(same_channels(11'd2047));
        set_config(11'd2047, 6'd63);
        send_good(same_channels(11'd0));
        set_config(11'd2047, 6'd0);
        send_good(same_channels(11'd0));
        // Switch thresholds around the reset center.
        set_config(CENTER_RST, GAIN_RST);
        pl = same_channels(11'd1234);
        pl[11*4 +: 11] = 11'd1792;
        pl[11*5 +: 11] = 11'd192;
        pl[11*6 +: 11] = 11'd1791;
        pl[11*7 +: 11] = 11'd193;
        send_good(pl);
    endtask

    task automatic run_traffic(input int frame_bytes);
        int done;
        int pick;
        int len;
        done = 0;
        while (done < frame_bytes) begin
            pick = $urandom_range(99);
            if (pick < 68) begin
                send_good(random_payload());
                done += FRAME_LEN;
                if ($urandom_range(3) == 0) send_noise($urandom_range(1, 4), 0);
            end else if (pick < 76) begin
                send_frame(random_payload(), HDR_BYTE ^ (8'd1 << $urandom_range(7)),
                           8'($urandom_range(255)), END_BYTE, FRAME_LEN);
                done += FRAME_LEN;
            end else if (pick < 84) begin
                send_frame(random_payload(), HDR_BYTE, 8'($urandom_range(255)),
                           8'($urandom_range(1, 255)), FRAME_LEN);
                done += FRAME_LEN;
            end else if (pick < 92) begin
                len = $urandom_range(1, FRAME_LEN - 1);
                send_frame(random_payload(), HDR_BYTE, 8'($urandom_range(255)),
                           END_BYTE, len);
                done += len;
            end else begin
                send_noise($urandom_range(1, 30), 10);
            end
        end
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin src_idle_pct = 31; sink_idle_pct = 64; end
                1: begin src_idle_pct = 64; sink_idle_pct = 31; end
                default: begin src_idle_pct = 0; sink_idle_pct = 0; end
            endcase
            set_config(phase == 1 ? 11'd2047 : 11'd0, phase == 2 ? 6'd0 : 6'd63);
            run_traffic(180);
            set_config(11'($urandom_range(2047)), 6'($urandom_range(63)));
            run_traffic(180);
        end
    endtask

    // The receiver stalls long enough for decoded frames to back up and the
    // decoder to hold off its byte input while bytes keep being offered.
    task automatic test_backpressure();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        set_config(11'($urandom_range(2047)), 6'($urandom_range(63)));
        hold_ask++;
        for (int i = 0; i < 14; i++) begin
            send_good(random_payload());
        end
    endtask

    task automatic finish_run();
        wait_drained();
        $display("Covered %0d byte transfers, %0d well-formed frames, %0d results checked,",
                 bytes_sent, frames_sent, results_checked);
        $display("across %0d register settings with idle and back-pressure phases.",
                 settings_used);
        if (mismatches == 0 && frames_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_values();
        test_special_cases();
        test_config_extremes();
        test_random_traffic();
        test_backpressure();
        finish_run();
    end

endmodule
